// ===== rtl/flpa_pkg.sv =====
// Shared types and constants for the free-list pool allocator.
`default_nettype none

package flpa_pkg;

    localparam int POOL_SLOTS_DEFAULT = 256;
    localparam int DATA_W             = 16;

    localparam logic [DATA_W-1:0] POOL_BASE_RESET = 16'd0;
    localparam logic [DATA_W-1:0] SLOT_SIZE_RESET = 16'd64;

    // configuration register indexes
    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_SLOT_SIZE = 1'b1;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_GRANT      = 2'd0,
        ST_HEAP_ALLOC = 2'd1,
        ST_RETURN     = 2'd2,
        ST_HEAP_FREE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_FILL
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/free_list_pool_allocator_core.sv =====
// Top level of the free-list pool allocator: ports, config and input registers.
// A granting allocate is decoded, then fetches the head link, with busy high while it decodes;
//   any other word leaves busy low, except a free past the high-water mark, which holds
//   busy high while it writes one link RAM entry per skipped slot, then pushes the slot.
// done is registered at decode, or at the end of the fill for such a free.
// rst_n clears all control state asynchronously; link RAM contents are not cleared.
`default_nettype none

module free_list_pool_allocator_core
    import flpa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEFAULT,
    localparam int IW = $clog2(POOL_SLOTS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command word
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              cmd,
    input  wire logic [DATA_W-1:0] request_size,
    input  wire logic [DATA_W-1:0] item_address,
    // result word
    output logic                   done,
    output logic      [1:0]        status,
    output logic      [DATA_W-1:0] slot_address,
    // config write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data
);

    logic              accept;
    logic              cfg_write;

    // config registers
    logic [DATA_W-1:0] pool_base_reg;
    logic [DATA_W-1:0] slot_size_reg;

    // input word register, loaded on accept
    logic              cmd_reg;
    logic [DATA_W-1:0] size_reg;
    logic [DATA_W-1:0] item_addr_reg;

    // link RAM port
    logic              ram_wr_en;
    logic [IW-1:0]     ram_wr_addr;
    logic [IW-1:0]     ram_wr_data;
    logic [IW-1:0]     ram_rd_addr;
    logic [IW-1:0]     ram_rd_data;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= POOL_BASE_RESET;
            slot_size_reg <= SLOT_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_POOL_BASE: pool_base_reg <= cfg_data;
                REG_SLOT_SIZE: slot_size_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd;
            size_reg      <= request_size;
            item_addr_reg <= item_address;
        end
    end

    // free-list engine: decode, head/high-water state, result register
    flpa_engine #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd_reg),
        .request_size (size_reg),
        .item_address (item_addr_reg),
        .pool_base    (pool_base_reg),
        .slot_size    (slot_size_reg),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .slot_address (slot_address),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    // per-slot next links
    flpa_link_ram #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/flpa_link_ram.sv =====
// Link memory: one write port, one registered read port.
`default_nettype none

module flpa_link_ram
    import flpa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEFAULT,
    localparam int IW = $clog2(POOL_SLOTS)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [IW-1:0] wr_data,
    input  wire logic [IW-1:0] rd_addr,
    output logic      [IW-1:0] rd_data
);

    logic [IW-1:0] mem [POOL_SLOTS];
    logic [IW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/flpa_engine.sv =====
// Free-list state, command decode and result register.
`default_nettype none

module flpa_engine
    import flpa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEFAULT,
    localparam int IW = $clog2(POOL_SLOTS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              cmd,
    input  wire logic [DATA_W-1:0] request_size,
    input  wire logic [DATA_W-1:0] item_address,
    input  wire logic [DATA_W-1:0] pool_base,
    input  wire logic [DATA_W-1:0] slot_size,
    output logic                   busy,
    output logic                   done,
    output logic      [1:0]        status,
    output logic      [DATA_W-1:0] slot_address,
    output logic                   ram_wr_en,
    output logic      [IW-1:0]     ram_wr_addr,
    output logic      [IW-1:0]     ram_wr_data,
    output logic      [IW-1:0]     ram_rd_addr,
    input  wire logic [IW-1:0]     ram_rd_data
);

    localparam logic [DATA_W:0] SLOTS_LIMIT = (DATA_W+1)'(POOL_SLOTS);

    // link of a slot that was never written: next slot, last slot ends the chain
    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] j);
        logic [IW-1:0] r;
        r = (j == IW'(POOL_SLOTS - 1)) ? '0 : j + 1'b1;
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic              made_reg, made_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     head_link_reg, head_link_next;
    logic [IW:0]       fresh_reg, fresh_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] addr_reg, addr_next;

    // decode of the registered command
    logic              fits;
    logic [IW-1:0]     eff_head;
    logic [IW-1:0]     eff_link;
    logic [DATA_W-1:0] idx_full;
    logic              in_range;
    logic [IW-1:0]     idx_now;
    logic              do_pop;
    logic              do_gap;
    logic              do_push;
    logic              fill_step;
    logic [IW-1:0]     push_idx;

    always_comb
    begin
        fits     = (request_size <= slot_size);
        eff_head = made_reg ? head_reg : IW'(1);
        eff_link = made_reg ? head_link_reg : next_slot(IW'(1));
        idx_full = item_address - pool_base;
        in_range = made_reg && (idx_full != '0) && ({1'b0, idx_full} < SLOTS_LIMIT);
        idx_now  = idx_full[IW-1:0];

        do_pop    = (state_reg == S_EXEC) && (cmd == CMD_ALLOC) && fits
                    && (eff_head != '0);
        do_gap    = (state_reg == S_EXEC) && (cmd == CMD_FREE) && in_range
                    && ({1'b0, idx_now} > fresh_reg);
        fill_step = (state_reg == S_FILL) && (fresh_reg != {1'b0, idx_reg});
        do_push   = ((state_reg == S_EXEC) && (cmd == CMD_FREE) && in_range && !do_gap)
                    || ((state_reg == S_FILL) && !fill_step);
        push_idx  = (state_reg == S_FILL) ? idx_reg : idx_now;

        busy = do_pop || do_gap || fill_step;
    end

    // next state
    always_comb
    begin
        state_next = S_IDLE;
        if (accept)
        begin
            state_next = S_EXEC;
        end
        else if (do_pop)
        begin
            state_next = S_LOAD;
        end
        else if (do_gap || fill_step)
        begin
            state_next = S_FILL;
        end
    end

    // datapath and result
    always_comb
    begin
        made_next      = made_reg;
        head_next      = head_reg;
        head_link_next = head_link_reg;
        fresh_next     = fresh_reg;
        idx_next       = idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        addr_next      = addr_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = push_idx;
        ram_wr_data    = head_reg;
        ram_rd_addr    = eff_link;

        case (state_reg)
            S_EXEC:
            begin
                idx_next = idx_now;
                if (cmd == CMD_ALLOC)
                begin
                    done_next = 1'b1;
                    addr_next = '0;
                    if (!fits)
                    begin
                        status_next = ST_HEAP_ALLOC;
                    end
                    else
                    begin
                        made_next = 1'b1;
                        if (eff_head == '0)
                        begin
                            status_next = ST_HEAP_ALLOC;
                        end
                        else
                        begin
                            head_next   = eff_link;
                            status_next = ST_GRANT;
                            addr_next   = pool_base + DATA_W'(eff_head);
                            if ({1'b0, eff_head} >= fresh_reg)
                            begin
                                fresh_next = {1'b0, eff_head} + 1'b1;
                            end
                        end
                    end
                end
                else if (!in_range)
                begin
                    done_next   = 1'b1;
                    status_next = ST_HEAP_FREE;
                    addr_next   = '0;
                end
            end
            S_LOAD:
            begin
                // link of the new head: RAM once written, else implicit chain
                head_link_next = ({1'b0, head_reg} >= fresh_reg) ? next_slot(head_reg)
                                                                  : ram_rd_data;
            end
            S_FILL:
            begin
                if (fill_step)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = fresh_reg[IW-1:0];
                    ram_wr_data = next_slot(fresh_reg[IW-1:0]);
                    fresh_next  = fresh_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_push)
        begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = push_idx;
            ram_wr_data    = head_reg;
            head_link_next = head_reg;
            head_next      = push_idx;
            if ({1'b0, push_idx} >= fresh_reg)
            begin
                fresh_next = {1'b0, push_idx} + 1'b1;
            end
            done_next   = 1'b1;
            status_next = ST_RETURN;
            addr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            made_reg      <= 1'b0;
            head_reg      <= '0;
            head_link_reg <= '0;
            fresh_reg     <= (IW+1)'(1);
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            made_reg      <= made_next;
            head_reg      <= head_next;
            head_link_reg <= head_link_next;
            fresh_reg     <= fresh_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_address = addr_reg;

endmodule

`default_nettype wire
